// ===== hw/rtl/dwsm_pkg.sv =====
`timescale 1ns / 1ps

package dwsm_pkg;

    // fixed field widths of the transactions
    localparam int unsigned SCALE_W     = 16;
    localparam int unsigned EDGE_W      = 4;
    localparam int unsigned OUT_SPEED_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_ADDR_W  = 1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_SCALE       = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EDGES_PER_MEASURE = 1'b1;

    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST       = 16'd5105;
    localparam logic [EDGE_W-1:0]  EDGES_PER_MEASURE_RST = 4'd4;

    typedef struct packed {
        logic left_level;
        logic right_level;
    } t_in;

    typedef struct packed {
        logic [OUT_SPEED_W-1:0] left_speed_out;
        logic [OUT_SPEED_W-1:0] right_speed_out;
        logic                   left_updated;
        logic                   right_updated;
    } t_out;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_LWAIT,
        ST_RIGHT,
        ST_RWAIT,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/dwsm_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module dwsm_div #(
    parameter int unsigned NUM_W = 18,
    parameter int unsigned DEN_W = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    output dwsm_pkg::t_div_stat  o_stat,
    output logic [NUM_W-1:0]     o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

endmodule

// ===== hw/rtl/dual_wheel_period_speed_meter_top.sv =====
`timescale 1ns / 1ps
// sequence: the input transaction leads to ST_LEFT, ST_RIGHT, ST_DONE, with a wait in
//   ST_LWAIT or ST_RWAIT for each wheel that measures on the shared serial divider
// flow: the input stalls until the result is loaded into the output register, so
//   a new transaction waits; a stalled output register stretches this further
// reset: synchronous active-low i_rst_n clears counters, speeds and levels,
//   loads speed_scale = 5105 and edges_per_measure = 4

module dual_wheel_period_speed_meter_top #(
    parameter int unsigned TICK_COUNT_WIDTH = 8,
    parameter int unsigned SPEED_WIDTH      = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  dwsm_pkg::t_in                       i_in_data,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output dwsm_pkg::t_out                      o_out_data,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [dwsm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dwsm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int unsigned TW     = TICK_COUNT_WIDTH;
    // numerator 2*scale + ticks, one bit above the wider addend
    localparam int unsigned NUM_W  = ((2 * dwsm_pkg::SCALE_W > 2 * TW) ?
                                      dwsm_pkg::SCALE_W : TW) + 2;
    localparam int unsigned DEN_W  = TW + 1;
    localparam logic [TW-1:0]    TICK_MAX  = {TW{1'b1}};
    localparam logic [NUM_W-1:0] SPEED_MAX = NUM_W'({SPEED_WIDTH{1'b1}});

    // configuration registers
    logic [dwsm_pkg::SCALE_W-1:0] r_scale;
    logic [dwsm_pkg::EDGE_W-1:0]  r_epm;

    // per-wheel state
    logic                         r_l_last, r_r_last;
    logic [dwsm_pkg::EDGE_W-1:0]  r_l_edges, r_r_edges;
    logic [TW-1:0]                r_l_ticks, r_r_ticks;
    logic [SPEED_WIDTH-1:0]       r_l_speed, r_r_speed;

    // measurement requests latched at the input transaction
    logic                         r_l_trig, r_r_trig;
    logic [TW-1:0]                r_l_div, r_r_div;

    // sequencer and output register
    dwsm_pkg::t_state             r_state, n_state;
    logic                         r_out_valid;
    dwsm_pkg::t_out               r_out_data;

    logic                         in_acc;
    logic                         out_load;
    logic                         div_start;
    logic                         div_sel_right;
    logic [NUM_W-1:0]             div_num;
    logic [DEN_W-1:0]             div_den;
    dwsm_pkg::t_div_stat          div_stat;
    logic [NUM_W-1:0]             div_quot;
    logic [SPEED_WIDTH-1:0]       sat_speed;

    // next tick counts, saturating
    logic [TW-1:0]                l_tick_nx, r_tick_nx;
    logic [dwsm_pkg::EDGE_W:0]    l_edge_nx, r_edge_nx;
    logic                         l_edge, r_edge;
    logic                         l_meas, r_meas;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != dwsm_pkg::ST_IDLE);

    assign l_tick_nx = (r_l_ticks == TICK_MAX) ? r_l_ticks : r_l_ticks + 1'b1;
    assign r_tick_nx = (r_r_ticks == TICK_MAX) ? r_r_ticks : r_r_ticks + 1'b1;
    assign l_edge    = (i_in_data.left_level  != r_l_last);
    assign r_edge    = (i_in_data.right_level != r_r_last);
    assign l_edge_nx = {1'b0, r_l_edges} + 1'b1;
    assign r_edge_nx = {1'b0, r_r_edges} + 1'b1;
    // a setting below the running count measures on the next edge
    assign l_meas    = l_edge && (l_edge_nx >= {1'b0, r_epm});
    assign r_meas    = r_edge && (r_edge_nx >= {1'b0, r_epm});

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= dwsm_pkg::SPEED_SCALE_RST;
            r_epm   <= dwsm_pkg::EDGES_PER_MEASURE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dwsm_pkg::CFG_SPEED_SCALE: begin
                    r_scale <= i_cfg_wdata[dwsm_pkg::SCALE_W-1:0];
                end
                dwsm_pkg::CFG_EDGES_PER_MEASURE: begin
                    r_epm <= i_cfg_wdata[dwsm_pkg::EDGE_W-1:0];
                end
                default: begin
                    r_epm <= r_epm;
                end
            endcase
        end
    end

    // shared divider operands: (2*scale + ticks) / (2*ticks)
    logic [TW-1:0] div_ticks;
    assign div_ticks = div_sel_right ? r_r_div : r_l_div;
    assign div_num   = {{(NUM_W - dwsm_pkg::SCALE_W - 1){1'b0}}, r_scale, 1'b0}
                     + NUM_W'(div_ticks);
    assign div_den   = {div_ticks, 1'b0};

    dwsm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // speed saturates at the top of its range
    assign sat_speed = (div_quot > SPEED_MAX) ? {SPEED_WIDTH{1'b1}}
                                              : div_quot[SPEED_WIDTH-1:0];

    // sequencer: left division, right division, each only when requested, then hand off the result
    always_comb begin
        n_state       = r_state;
        div_start     = 1'b0;
        div_sel_right = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            dwsm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = dwsm_pkg::ST_LEFT;
                end
            end
            dwsm_pkg::ST_LEFT: begin
                if (r_l_trig) begin
                    div_start = 1'b1;
                    n_state   = dwsm_pkg::ST_LWAIT;
                end else begin
                    n_state = dwsm_pkg::ST_RIGHT;
                end
            end
            dwsm_pkg::ST_LWAIT: begin
                if (div_stat.done) begin
                    n_state = dwsm_pkg::ST_RIGHT;
                end
            end
            dwsm_pkg::ST_RIGHT: begin
                div_sel_right = 1'b1;
                if (r_r_trig) begin
                    div_start = 1'b1;
                    n_state   = dwsm_pkg::ST_RWAIT;
                end else begin
                    n_state = dwsm_pkg::ST_DONE;
                end
            end
            dwsm_pkg::ST_RWAIT: begin
                div_sel_right = 1'b1;
                if (div_stat.done) begin
                    n_state = dwsm_pkg::ST_DONE;
                end
            end
            dwsm_pkg::ST_DONE: begin
                // wait for room in the output register
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = dwsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dwsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwsm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // wheel state update at the input transaction, speeds loaded when a division completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_last  <= 1'b0;
            r_r_last  <= 1'b0;
            r_l_edges <= '0;
            r_r_edges <= '0;
            r_l_ticks <= '0;
            r_r_ticks <= '0;
            r_l_speed <= '0;
            r_r_speed <= '0;
            r_l_trig  <= 1'b0;
            r_r_trig  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_l_last <= i_in_data.left_level;
                r_r_last <= i_in_data.right_level;
                r_l_trig <= l_meas;
                r_r_trig <= r_meas;
                if (l_meas) begin
                    r_l_edges <= '0;
                    r_l_ticks <= '0;
                end else begin
                    r_l_ticks <= l_tick_nx;
                    if (l_edge) begin
                        r_l_edges <= l_edge_nx[dwsm_pkg::EDGE_W-1:0];
                    end
                end
                if (r_meas) begin
                    r_r_edges <= '0;
                    r_r_ticks <= '0;
                end else begin
                    r_r_ticks <= r_tick_nx;
                    if (r_edge) begin
                        r_r_edges <= r_edge_nx[dwsm_pkg::EDGE_W-1:0];
                    end
                end
            end
            if (div_stat.done && r_state == dwsm_pkg::ST_LWAIT) begin
                r_l_speed <= sat_speed;
            end
            if (div_stat.done && r_state == dwsm_pkg::ST_RWAIT) begin
                r_r_speed <= sat_speed;
            end
        end
    end

    // divisor snapshot, the tick count including this tick
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l_div <= l_tick_nx;
            r_r_div <= r_tick_nx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.left_speed_out  <= r_l_speed[dwsm_pkg::OUT_SPEED_W-1:0];
            r_out_data.right_speed_out <= r_r_speed[dwsm_pkg::OUT_SPEED_W-1:0];
            r_out_data.left_updated    <= r_l_trig;
            r_out_data.right_updated   <= r_r_trig;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // divider is never left running while the sequencer is idle
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dwsm_pkg::ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    // a quotient only arrives while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == dwsm_pkg::ST_LWAIT ||
                           r_state == dwsm_pkg::ST_RWAIT))
        else $error("divider result outside a wait state");

    // a new result follows the hand-off state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == dwsm_pkg::ST_DONE)
        else $error("result raised outside hand-off");

    // no division is started for a wheel that did not request one
    a_start_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> ((r_state == dwsm_pkg::ST_LEFT && r_l_trig) ||
                       (r_state == dwsm_pkg::ST_RIGHT && r_r_trig)))
        else $error("division started without request");

endmodule
